// File: sv/clas_pkg.sv
// ----------------------------------------------------------------------------
// clas_pkg
// Shared types, codes and constants of the command line argument splitter.
// ----------------------------------------------------------------------------
package clas_pkg;

	// command line characters
	localparam logic [7:0] QUOTE_CH  = 8'h22;
	localparam logic [7:0] BSLASH_CH = 8'h5C;
	localparam logic [7:0] SPACE_CH  = 8'h20;
	localparam logic [7:0] TAB_CH    = 8'h09;
	localparam logic [7:0] CR_CH     = 8'h0D;

	// line and argument limits
	localparam int unsigned LINE_BYTES = 4096;
	localparam int unsigned MAX_ARGS   = 256;
	localparam int unsigned POS_W      = $clog2(LINE_BYTES);
	localparam int unsigned CNT_W      = $clog2(MAX_ARGS) + 1;
	localparam int unsigned IDX_W      = $clog2(MAX_ARGS);

	// most results one input byte can cause
	localparam int unsigned MAX_RES = 3;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BYTES    = 2'd0,
		KIND_ARG_END  = 2'd1,
		KIND_LINE_END = 2'd2
	} kind_t;

	// quote cycle
	typedef enum logic [1:0] {
		QP_OUTSIDE = 2'd0,
		QP_INSIDE  = 2'd1,
		QP_CLOSED  = 2'd2
	} quote_phase_t;

	// one result item
	typedef struct packed {
		kind_t             kind;
		logic [7:0]        value;
		logic [7:0]        repeat_res;
		logic [IDX_W-1:0]  arg_index;
		logic [POS_W-1:0]  arg_start;
		logic [CNT_W-1:0]  arg_count;
		logic              last;
	} res_t;

	function automatic res_t make_res(kind_t kind, logic [7:0] value, logic [7:0] rep,
			logic [IDX_W-1:0] idx, logic [POS_W-1:0] start, logic [CNT_W-1:0] count);
		res_t r;
		r.kind       = kind;
		r.value      = value;
		r.repeat_res = rep;
		r.arg_index  = idx;
		r.arg_start  = start;
		r.arg_count  = count;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

// File: sv/clas_cmd_if.sv
// ----------------------------------------------------------------------------
// clas_cmd_if
// Input channel: one command line byte or an end-of-line mark per transfer.
// ----------------------------------------------------------------------------
interface clas_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_line;

	modport source (output valid, output ch, output end_of_line, input ready);
	modport sink (input valid, input ch, input end_of_line, output ready);
endinterface

// File: sv/clas_res_if.sv
// ----------------------------------------------------------------------------
// clas_res_if
// Result channel: argument bytes, end of argument or end of line per transfer.
// ----------------------------------------------------------------------------
interface clas_res_if;
	import clas_pkg::*;

	logic             valid;
	logic             ready;
	kind_t            kind;
	logic [7:0]       value;
	logic [7:0]       repeat_res;
	logic [IDX_W-1:0] arg_index;
	logic [POS_W-1:0] arg_start;
	logic [CNT_W-1:0] arg_count;
	logic             last;

	modport source (output valid, output kind, output value, output repeat_res,
		output arg_index, output arg_start, output arg_count, output last, input ready);
	modport sink (input valid, input kind, input value, input repeat_res,
		input arg_index, input arg_start, input arg_count, input last, output ready);
endinterface

// File: sv/command_line_argument_splitter_top.sv
// ----------------------------------------------------------------------------
// command_line_argument_splitter_top
// Splits a byte stream of a command line into arguments with quote and
// backslash handling; reports byte runs, argument ends and the line end.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one byte (or an end-of-line mark) per transfer, res carries
//   one result per transfer. Each accepted input causes zero to three
//   results; the last one has last set.
//   The splitter state and the results of an input are computed in the
//   cycle the input is taken and stored in a three-entry result buffer.
//   The first result is offered on res the cycle after the transfer; the
//   buffer then drains one result per cycle while res is ready.
//   Flow: an input is taken in the same cycle the final buffered result
//   leaves; three results at most (end of line with pending backslashes
//   in an open argument). Inputs with no result are taken back to back.
//   When res stalls the buffer holds its entries and cmd.ready stays low.
//   Reset clears the splitter state and empties the buffer; an end of line
//   also returns the state to its reset values.
// ----------------------------------------------------------------------------
module command_line_argument_splitter_top (
	input  logic       clk,
	input  logic       arst_n,
	clas_cmd_if.sink   cmd,
	clas_res_if.source res
);
	import clas_pkg::*;

	// splitter state
	logic             in_arg_q;
	quote_phase_t     qphase_q;
	logic [7:0]       pend_q;
	logic [CNT_W-1:0] total_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] start_q;

	// next state and results of the offered input
	logic             nxt_in_arg;
	quote_phase_t     nxt_qphase;
	logic [7:0]       nxt_pend;
	logic [CNT_W-1:0] nxt_total;
	logic [POS_W-1:0] nxt_pos;
	logic [POS_W-1:0] nxt_start;
	res_t             ent [MAX_RES];
	logic [1:0]       n_ent;

	// result buffer
	res_t       buf_q [MAX_RES];
	logic [1:0] cnt_q;
	logic [1:0] rd_q;

	logic             cur_is_space;
	logic [IDX_W-1:0] cur_idx;
	logic [7:0]       b_pend;
	quote_phase_t     b_qphase;
	logic             cmd_xfer;
	logic             res_xfer;
	logic             drain_last;
	res_t             head;

	assign cur_is_space = (cmd.ch == SPACE_CH) || ((cmd.ch >= TAB_CH) && (cmd.ch <= CR_CH));
	assign cur_idx = total_q[CNT_W-1] ? {IDX_W{1'b1}} : total_q[IDX_W-1:0];

	// state after an implicit argument start
	assign b_pend   = in_arg_q ? pend_q : 8'd0;
	assign b_qphase = in_arg_q ? qphase_q : QP_OUTSIDE;

	// splitting rules for one input
	always_comb begin
		nxt_in_arg = in_arg_q;
		nxt_qphase = qphase_q;
		nxt_pend   = pend_q;
		nxt_total  = total_q;
		nxt_pos    = pos_q;
		nxt_start  = start_q;
		n_ent      = 2'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			ent[i] = '0;
		end

		if (cmd.end_of_line) begin
			// flush and close an open argument, then report the count
			if (in_arg_q) begin
				if (pend_q != 8'd0) begin
					ent[n_ent] = make_res(KIND_BYTES, BSLASH_CH, pend_q, cur_idx, '0, '0);
					n_ent = n_ent + 2'd1;
				end
				ent[n_ent] = make_res(KIND_ARG_END, 8'd0, 8'd0, cur_idx, start_q, '0);
				n_ent = n_ent + 2'd1;
				if (!total_q[CNT_W-1]) begin
					nxt_total = total_q + 1'b1;
				end
			end
			ent[n_ent] = make_res(KIND_LINE_END, 8'd0, 8'd0, '0, '0, nxt_total);
			n_ent = n_ent + 2'd1;
			nxt_in_arg = 1'b0;
			nxt_qphase = QP_OUTSIDE;
			nxt_pend   = 8'd0;
			nxt_total  = '0;
			nxt_pos    = '0;
			nxt_start  = '0;
		end else begin
			nxt_pos = pos_q + 1'b1;
			if (cur_is_space) begin
				if (in_arg_q) begin
					if (pend_q != 8'd0) begin
						ent[n_ent] = make_res(KIND_BYTES, BSLASH_CH, pend_q, cur_idx, '0, '0);
						n_ent = n_ent + 2'd1;
					end
					nxt_pend = 8'd0;
					if (qphase_q == QP_INSIDE) begin
						// quoted whitespace is an argument byte
						ent[n_ent] = make_res(KIND_BYTES, cmd.ch, 8'd1, cur_idx, '0, '0);
						n_ent = n_ent + 2'd1;
					end else begin
						ent[n_ent] = make_res(KIND_ARG_END, 8'd0, 8'd0, cur_idx, start_q, '0);
						n_ent = n_ent + 2'd1;
						if (!total_q[CNT_W-1]) begin
							nxt_total = total_q + 1'b1;
						end
						nxt_in_arg = 1'b0;
						nxt_qphase = QP_OUTSIDE;
					end
				end
			end else begin
				nxt_in_arg = 1'b1;
				if (!in_arg_q) begin
					nxt_start = pos_q;
				end
				if (cmd.ch == BSLASH_CH) begin
					nxt_qphase = (b_qphase == QP_INSIDE) ? QP_INSIDE : QP_OUTSIDE;
					nxt_pend   = (b_pend == 8'hFF) ? 8'hFF : b_pend + 8'd1;
				end else if (cmd.ch == QUOTE_CH) begin
					nxt_pend   = 8'd0;
					nxt_qphase = b_qphase;
					// backslash pairs before a quote
					if (b_pend[7:1] != 7'd0) begin
						ent[n_ent] = make_res(KIND_BYTES, BSLASH_CH, {1'b0, b_pend[7:1]},
							cur_idx, '0, '0);
						n_ent = n_ent + 2'd1;
					end
					if (b_pend[0]) begin
						// escaped quote
						ent[n_ent] = make_res(KIND_BYTES, QUOTE_CH, 8'd1, cur_idx, '0, '0);
						n_ent = n_ent + 2'd1;
					end else begin
						case (b_qphase)
							QP_INSIDE: nxt_qphase = QP_CLOSED;
							QP_CLOSED: begin
								ent[n_ent] = make_res(KIND_BYTES, QUOTE_CH, 8'd1, cur_idx, '0, '0);
								n_ent = n_ent + 2'd1;
								nxt_qphase = QP_OUTSIDE;
							end
							default: nxt_qphase = QP_INSIDE;
						endcase
					end
				end else begin
					nxt_qphase = (b_qphase == QP_INSIDE) ? QP_INSIDE : QP_OUTSIDE;
					nxt_pend   = 8'd0;
					if (b_pend != 8'd0) begin
						ent[n_ent] = make_res(KIND_BYTES, BSLASH_CH, b_pend, cur_idx, '0, '0);
						n_ent = n_ent + 2'd1;
					end
					ent[n_ent] = make_res(KIND_BYTES, cmd.ch, 8'd1, cur_idx, '0, '0);
					n_ent = n_ent + 2'd1;
				end
			end
		end

		// mark the final result of this input
		if (n_ent != 2'd0) begin
			ent[n_ent - 2'd1].last = 1'b1;
		end
	end

	// handshakes
	assign head       = buf_q[rd_q];
	assign res_xfer   = res.valid && res.ready;
	assign drain_last = res_xfer && (rd_q == cnt_q - 2'd1);
	assign cmd.ready  = (cnt_q == 2'd0) || drain_last;
	assign cmd_xfer   = cmd.valid && cmd.ready;

	// state and buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_arg_q <= 1'b0;
			qphase_q <= QP_OUTSIDE;
			pend_q   <= 8'd0;
			total_q  <= '0;
			pos_q    <= '0;
			start_q  <= '0;
			cnt_q    <= 2'd0;
			rd_q     <= 2'd0;
		end else if (cmd_xfer) begin
			in_arg_q <= nxt_in_arg;
			qphase_q <= nxt_qphase;
			pend_q   <= nxt_pend;
			total_q  <= nxt_total;
			pos_q    <= nxt_pos;
			start_q  <= nxt_start;
			cnt_q    <= n_ent;
			rd_q     <= 2'd0;
		end else if (drain_last) begin
			cnt_q <= 2'd0;
			rd_q  <= 2'd0;
		end else if (res_xfer) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			for (int i = 0; i < MAX_RES; i++) begin
				buf_q[i] <= ent[i];
			end
		end
	end

	// result channel
	assign res.valid      = (cnt_q != 2'd0);
	assign res.kind       = head.kind;
	assign res.value      = head.value;
	assign res.repeat_res = head.repeat_res;
	assign res.arg_index  = head.arg_index;
	assign res.arg_start  = head.arg_start;
	assign res.arg_count  = head.arg_count;
	assign res.last       = head.last;

endmodule
